// File: hw/rtl/cau_pkg.sv
// cau_pkg: shared types and codes for the complex arithmetic unit.
// No dependencies; imported by the top level and its checker.
package cau_pkg;

    localparam int C_PART_W = 16;

    // delay from an accepted input item to its result strobe
    localparam int C_LATENCY = C_PART_W + 6;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef struct packed {
        logic [1:0]                 opcode;
        logic signed [C_PART_W-1:0] a_re;
        logic signed [C_PART_W-1:0] a_im;
        logic signed [C_PART_W-1:0] b_re;
        logic signed [C_PART_W-1:0] b_im;
    } t_operands;

    typedef struct packed {
        logic signed [C_PART_W-1:0] res_re;
        logic signed [C_PART_W-1:0] res_im;
        logic [1:0]                 status;
    } t_result;

endpackage

// File: hw/rtl/complex_arithmetic_unit.sv
// Result: each accepted item passes stages 0 to 3, the divider pipe and the output
//   register; o_strobe is high for a single cycle with it. Parts are Q8.8 by default.
// Throughput: one item per clock outside reset; the divide path is one pipeline stage per quotient
//   bit (C_PART_W stages), so every opcode takes the same number of cycles.
// Reset: synchronous, active low; clears all pipeline valid bits. busy is high only
//   while reset is held. The receiver cannot stall, so the pipe never stops.
module complex_arithmetic_unit #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  cau_pkg::t_operands  i_operands,
    output logic                o_strobe,
    output cau_pkg::t_result    o_result
);
    import cau_pkg::*;

    // widths
    localparam int W  = C_PART_W;
    localparam int F  = int'(FRAC_BITS);
    localparam int PW = 2 * W;          // signed product
    localparam int SW = 2 * W + 1;      // signed sum of two products
    localparam int MW = 2 * W;          // magnitude of numerator / denominator
    localparam int DW = 3 * W + F;      // divider remainder / compare width

    localparam logic signed [SW-1:0] LIM_P = {{(W + 2){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [SW-1:0] LIM_N = ~LIM_P;
    localparam logic [W-1:0] Q_P = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0] Q_N = {1'b1, {(W - 1){1'b0}}};

    // clamp a signed wide value to W bits; msb of the result is the overflow flag
    function automatic logic [W:0] sat_lin(input logic signed [SW-1:0] v);
        logic [W:0] r;
        if (v > LIM_P) begin
            r = {1'b1, Q_P};
        end else if (v < LIM_N) begin
            r = {1'b1, Q_N};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    // sign-magnitude quotient to W bits; big means the quotient is 2^W or more
    function automatic logic [W:0] sat_quo(input logic neg, input logic big,
                                           input logic [W-1:0] q);
        logic [W:0] r;
        if (!neg) begin
            if (big || q > Q_P) begin
                r = {1'b1, Q_P};
            end else begin
                r = {1'b0, q};
            end
        end else begin
            if (big || q > Q_N) begin
                r = {1'b1, Q_N};
            end else begin
                r = {1'b0, W'(-q)};
            end
        end
        return r;
    endfunction

    logic in_take;

    // stage 0: input capture
    logic                r0_valid;
    logic [1:0]          r0_op;
    logic signed [W-1:0] r0_a_re, r0_a_im, r0_b_re, r0_b_im;

    // stage 1: products, add/sub
    logic                 r1_valid;
    logic [1:0]           r1_op;
    logic signed [PW-1:0] r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir, r1_p_bbr, r1_p_bbi;
    logic signed [W:0]    r1_as_re, r1_as_im;

    // stage 2: sums
    logic                 r2_valid;
    logic                 r2_div;
    logic signed [SW-1:0] r2_lin_re, r2_lin_im;
    logic signed [SW-1:0] r2_num_re, r2_num_im;
    logic [MW-1:0]        r2_den;
    logic signed [SW-1:0] n2_lin_re, n2_lin_im;

    // stage 3: saturate linear results, numerator magnitudes
    logic          r3_valid;
    logic          r3_div;
    logic          r3_dz;
    logic [W-1:0]  r3_lin_re, r3_lin_im;
    logic          r3_lin_ovf;
    logic          r3_neg_re, r3_neg_im;
    logic [MW-1:0] r3_mag_re, r3_mag_im;
    logic [MW-1:0] r3_den;
    logic [W:0]    n3_sat_re, n3_sat_im;

    // divider pipe: index 0 is loaded from stage 3, index i+1 resolves quotient bit W-1-i
    logic          r_dv_valid  [0:W];
    logic          r_dv_div    [0:W];
    logic          r_dv_dz     [0:W];
    logic [W-1:0]  r_dv_lin_re [0:W];
    logic [W-1:0]  r_dv_lin_im [0:W];
    logic          r_dv_lovf   [0:W];
    logic          r_dv_neg_re [0:W];
    logic          r_dv_neg_im [0:W];
    logic          r_dv_big_re [0:W];
    logic          r_dv_big_im [0:W];
    logic [MW-1:0] r_dv_den    [0:W];
    logic [DW-1:0] r_dv_rem_re [0:W];
    logic [DW-1:0] r_dv_rem_im [0:W];
    logic [W-1:0]  r_dv_q_re   [0:W];
    logic [W-1:0]  r_dv_q_im   [0:W];

    logic          n_dv_valid  [0:W];
    logic          n_dv_div    [0:W];
    logic          n_dv_dz     [0:W];
    logic [W-1:0]  n_dv_lin_re [0:W];
    logic [W-1:0]  n_dv_lin_im [0:W];
    logic          n_dv_lovf   [0:W];
    logic          n_dv_neg_re [0:W];
    logic          n_dv_neg_im [0:W];
    logic          n_dv_big_re [0:W];
    logic          n_dv_big_im [0:W];
    logic [MW-1:0] n_dv_den    [0:W];
    logic [DW-1:0] n_dv_rem_re [0:W];
    logic [DW-1:0] n_dv_rem_im [0:W];
    logic [W-1:0]  n_dv_q_re   [0:W];
    logic [W-1:0]  n_dv_q_im   [0:W];

    // output register
    logic          r_out_strobe;
    t_result       r_out;
    t_result       n_out;

    // never stalls; only reset holds items off
    assign busy    = ~i_rst_n;
    assign in_take = start & ~busy;

    // ---------------- control: valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid     <= 1'b0;
            r1_valid     <= 1'b0;
            r2_valid     <= 1'b0;
            r3_valid     <= 1'b0;
            r_dv_valid   <= '{default: 1'b0};
            r_out_strobe <= 1'b0;
        end else begin
            r0_valid     <= in_take;
            r1_valid     <= r0_valid;
            r2_valid     <= r1_valid;
            r3_valid     <= r2_valid;
            r_dv_valid   <= n_dv_valid;
            r_out_strobe <= r_dv_valid[W];
        end
    end

    // ---------------- stage 0 / 1 ----------------
    always_ff @(posedge i_clk) begin
        r0_op   <= i_operands.opcode;
        r0_a_re <= i_operands.a_re;
        r0_a_im <= i_operands.a_im;
        r0_b_re <= i_operands.b_re;
        r0_b_im <= i_operands.b_im;

        r1_op    <= r0_op;
        r1_p_rr  <= PW'(r0_a_re) * PW'(r0_b_re);
        r1_p_ii  <= PW'(r0_a_im) * PW'(r0_b_im);
        r1_p_ri  <= PW'(r0_a_re) * PW'(r0_b_im);
        r1_p_ir  <= PW'(r0_a_im) * PW'(r0_b_re);
        r1_p_bbr <= PW'(r0_b_re) * PW'(r0_b_re);
        r1_p_bbi <= PW'(r0_b_im) * PW'(r0_b_im);
        r1_as_re <= (r0_op == OP_SUB) ? (W + 1)'(r0_a_re) - (W + 1)'(r0_b_re)
                                      : (W + 1)'(r0_a_re) + (W + 1)'(r0_b_re);
        r1_as_im <= (r0_op == OP_SUB) ? (W + 1)'(r0_a_im) - (W + 1)'(r0_b_im)
                                      : (W + 1)'(r0_a_im) + (W + 1)'(r0_b_im);
    end

    // ---------------- stage 2 ----------------
    always_comb begin
        // multiply: floor shift of the exact sum
        if (r1_op == OP_MUL) begin
            n2_lin_re = (SW'(r1_p_rr) - SW'(r1_p_ii)) >>> F;
            n2_lin_im = (SW'(r1_p_ri) + SW'(r1_p_ir)) >>> F;
        end else begin
            n2_lin_re = SW'(r1_as_re);
            n2_lin_im = SW'(r1_as_im);
        end
    end

    always_ff @(posedge i_clk) begin
        r2_div    <= (r1_op == OP_DIV);
        r2_lin_re <= n2_lin_re;
        r2_lin_im <= n2_lin_im;
        // a * conj(b)
        r2_num_re <= SW'(r1_p_rr) + SW'(r1_p_ii);
        r2_num_im <= SW'(r1_p_ir) - SW'(r1_p_ri);
        r2_den    <= $unsigned(r1_p_bbr) + $unsigned(r1_p_bbi);
    end

    // ---------------- stage 3 ----------------
    assign n3_sat_re = sat_lin(r2_lin_re);
    assign n3_sat_im = sat_lin(r2_lin_im);

    always_ff @(posedge i_clk) begin
        r3_div     <= r2_div;
        r3_dz      <= (r2_den == '0);
        r3_lin_re  <= n3_sat_re[W-1:0];
        r3_lin_im  <= n3_sat_im[W-1:0];
        r3_lin_ovf <= n3_sat_re[W] | n3_sat_im[W];
        r3_neg_re  <= r2_num_re[SW-1];
        r3_neg_im  <= r2_num_im[SW-1];
        r3_mag_re  <= r2_num_re[SW-1] ? MW'(-r2_num_re) : MW'(r2_num_re);
        r3_mag_im  <= r2_num_im[SW-1] ? MW'(-r2_num_im) : MW'(r2_num_im);
        r3_den     <= r2_den;
    end

    // ---------------- divider pipe ----------------
    always_comb begin
        logic [DW-1:0] n_re;
        logic [DW-1:0] n_im;
        logic [DW-1:0] d_top;
        logic [DW-1:0] dsh;

        // entry: scale numerators, flag quotients of 2^W or more
        n_re  = DW'(r3_mag_re) << F;
        n_im  = DW'(r3_mag_im) << F;
        d_top = DW'(r3_den) << W;

        n_dv_valid[0]  = r3_valid;
        n_dv_div[0]    = r3_div;
        n_dv_dz[0]     = r3_dz;
        n_dv_lin_re[0] = r3_lin_re;
        n_dv_lin_im[0] = r3_lin_im;
        n_dv_lovf[0]   = r3_lin_ovf;
        n_dv_neg_re[0] = r3_neg_re;
        n_dv_neg_im[0] = r3_neg_im;
        n_dv_big_re[0] = (n_re >= d_top);
        n_dv_big_im[0] = (n_im >= d_top);
        n_dv_den[0]    = r3_den;
        n_dv_rem_re[0] = n_re;
        n_dv_rem_im[0] = n_im;
        n_dv_q_re[0]   = '0;
        n_dv_q_im[0]   = '0;

        // one restoring step per stage
        for (int i = 0; i < W; i++) begin
            dsh = DW'(r_dv_den[i]) << (W - 1 - i);

            n_dv_valid[i+1]  = r_dv_valid[i];
            n_dv_div[i+1]    = r_dv_div[i];
            n_dv_dz[i+1]     = r_dv_dz[i];
            n_dv_lin_re[i+1] = r_dv_lin_re[i];
            n_dv_lin_im[i+1] = r_dv_lin_im[i];
            n_dv_lovf[i+1]   = r_dv_lovf[i];
            n_dv_neg_re[i+1] = r_dv_neg_re[i];
            n_dv_neg_im[i+1] = r_dv_neg_im[i];
            n_dv_big_re[i+1] = r_dv_big_re[i];
            n_dv_big_im[i+1] = r_dv_big_im[i];
            n_dv_den[i+1]    = r_dv_den[i];
            n_dv_rem_re[i+1] = r_dv_rem_re[i];
            n_dv_rem_im[i+1] = r_dv_rem_im[i];
            n_dv_q_re[i+1]   = r_dv_q_re[i];
            n_dv_q_im[i+1]   = r_dv_q_im[i];

            if (r_dv_rem_re[i] >= dsh) begin
                n_dv_rem_re[i+1]          = r_dv_rem_re[i] - dsh;
                n_dv_q_re[i+1][W - 1 - i] = 1'b1;
            end
            if (r_dv_rem_im[i] >= dsh) begin
                n_dv_rem_im[i+1]          = r_dv_rem_im[i] - dsh;
                n_dv_q_im[i+1][W - 1 - i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_div    <= n_dv_div;
        r_dv_dz     <= n_dv_dz;
        r_dv_lin_re <= n_dv_lin_re;
        r_dv_lin_im <= n_dv_lin_im;
        r_dv_lovf   <= n_dv_lovf;
        r_dv_neg_re <= n_dv_neg_re;
        r_dv_neg_im <= n_dv_neg_im;
        r_dv_big_re <= n_dv_big_re;
        r_dv_big_im <= n_dv_big_im;
        r_dv_den    <= n_dv_den;
        r_dv_rem_re <= n_dv_rem_re;
        r_dv_rem_im <= n_dv_rem_im;
        r_dv_q_re   <= n_dv_q_re;
        r_dv_q_im   <= n_dv_q_im;
    end

    // ---------------- result select and saturation ----------------
    always_comb begin
        logic [W:0] s_re;
        logic [W:0] s_im;

        s_re = sat_quo(r_dv_neg_re[W], r_dv_big_re[W], r_dv_q_re[W]);
        s_im = sat_quo(r_dv_neg_im[W], r_dv_big_im[W], r_dv_q_im[W]);

        if (!r_dv_div[W]) begin
            n_out.res_re = r_dv_lin_re[W];
            n_out.res_im = r_dv_lin_im[W];
            n_out.status = r_dv_lovf[W] ? ST_SAT : ST_OK;
        end else if (r_dv_dz[W]) begin
            // zero divisor
            n_out.res_re = '0;
            n_out.res_im = '0;
            n_out.status = ST_DIV0;
        end else begin
            n_out.res_re = s_re[W-1:0];
            n_out.res_im = s_im[W-1:0];
            n_out.status = (s_re[W] | s_im[W]) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_out_strobe;
    assign o_result = r_out;

endmodule

// File: hw/rtl/cau_checker.sv
// cau_checker: port-level timing and status checks for complex_arithmetic_unit.
// Depends on cau_pkg; bound to the top level at the end of this file.
module cau_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input cau_pkg::t_operands i_operands,
    input logic               o_strobe,
    input cau_pkg::t_result   o_result
);
    import cau_pkg::*;

    // every accepted item comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##C_LATENCY o_strobe)
        else $error("accepted item did not produce a result on time");

    // no result without an item accepted at the matching edge
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, C_LATENCY))
        else $error("result strobe without a matching item");

    // zero divisor gives zero parts and the divide-by-zero status
    a_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operands.opcode == OP_DIV && i_operands.b_re == '0 &&
         i_operands.b_im == '0)
        |-> ##C_LATENCY (o_result.status == ST_DIV0 && o_result.res_re == '0 &&
                         o_result.res_im == '0))
        else $error("divide by zero not reported");

    // add and subtract never report divide by zero
    a_addsub_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operands.opcode == OP_ADD || i_operands.opcode == OP_SUB))
        |-> ##C_LATENCY (o_result.status != ST_DIV0))
        else $error("add/sub item reported divide by zero");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

// File: tb/complex_arithmetic_unit_test.sv
// Self-checking bench for complex_arithmetic_unit: add, subtract, multiply and divide
// in signed Q8.8, checked against an in-bench predictor. Depends on cau_pkg and the
// complex_arithmetic_unit RTL only.
`timescale 1ns / 100ps

module complex_arithmetic_unit_test;
    import cau_pkg::*;

    localparam int FRAC        = 8;
    localparam int STALL_LIMIT = 2000;
    localparam longint PART_MAX = (64'sd1 <<< (C_PART_W - 1)) - 1;
    localparam longint PART_MIN = -(64'sd1 <<< (C_PART_W - 1));

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      start      = 1'b0;
    logic      busy;
    t_operands i_operands = '0;
    logic      o_strobe;
    t_result   o_result;

    t_result   expected_results[$];
    int        error_count  = 0;
    int        item_count   = 0;
    int        result_count = 0;
    int        stall_cycles = 0;

    always #1 i_clk = ~i_clk;

    complex_arithmetic_unit #(
        .FRAC_BITS(FRAC)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_operands (i_operands),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Clamp to the part range; flags saturation.
    function automatic logic signed [C_PART_W-1:0] clamp_part(input longint v, inout bit sat);
        longint c;
        c = v;
        if (v > PART_MAX) begin
            c   = PART_MAX;
            sat = 1'b1;
        end else if (v < PART_MIN) begin
            c   = PART_MIN;
            sat = 1'b1;
        end
        return c[C_PART_W-1:0];
    endfunction

    // Exact arithmetic in 64 bits: products stay below 2^31, scaled numerators below 2^40.
    function automatic t_result predict_result(input t_operands op);
        longint  ar, ai, br, bi, re, im, den;
        bit      sat;
        t_result r;
        ar  = op.a_re;
        ai  = op.a_im;
        br  = op.b_re;
        bi  = op.b_im;
        re  = 0;
        im  = 0;
        sat = 1'b0;
        r   = '0;
        case (op.opcode)
            OP_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            OP_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            OP_MUL: begin
                // >>> on a signed value floors
                re = (ar * br - ai * bi) >>> FRAC;
                im = (ar * bi + ai * br) >>> FRAC;
            end
            OP_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.status = ST_DIV0;
                    return r;
                end
                // signed division truncates toward zero
                re = ((ar * br + ai * bi) <<< FRAC) / den;
                im = ((ai * br - ar * bi) <<< FRAC) / den;
            end
            default: ;
        endcase
        r.res_re = clamp_part(re, sat);
        r.res_im = clamp_part(im, sat);
        r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    // Accepted items push a prediction; strobed results are checked in order.
    always @(posedge i_clk) begin
        t_result want;
        bit      moved;
        moved = 1'b0;
        if (start === 1'b1 && busy === 1'b0) begin
            expected_results.push_back(predict_result(i_operands));
            item_count++;
            moved = 1'b1;
        end
        if (i_rst_n && o_strobe === 1'b1) begin
            result_count++;
            moved = 1'b1;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result re=%0d im=%0d status=%0d",
                                          o_result.res_re, o_result.res_im, o_result.status));
            end else begin
                want = expected_results.pop_front();
                if (o_result.res_re !== want.res_re)
                    report_mismatch($sformatf("res_re got %0d want %0d",
                                              o_result.res_re, want.res_re));
                if (o_result.res_im !== want.res_im)
                    report_mismatch($sformatf("res_im got %0d want %0d",
                                              o_result.res_im, want.res_im));
                if (o_result.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_result.status, want.status));
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
        $display("complex_arithmetic_unit_test: errors");
        $finish;
    end

    function automatic t_operands make_item(input logic [1:0] op, input longint ar,
                                            input longint ai, input longint br,
                                            input longint bi);
        t_operands item;
        item.opcode = op;
        item.a_re   = ar[C_PART_W-1:0];
        item.a_im   = ai[C_PART_W-1:0];
        item.b_re   = br[C_PART_W-1:0];
        item.b_im   = bi[C_PART_W-1:0];
        return item;
    endfunction

    // Hold start until the item is taken, then, with chance idle_pct percent, idle for a random stretch.
    task automatic send_item(input t_operands item, input int idle_pct);
        start      <= 1'b1;
        i_operands <= item;
        do @(posedge i_clk); while (busy !== 1'b0);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic test_add_sub_extremes();
        send_item(make_item(OP_ADD, PART_MAX, PART_MAX, PART_MAX, PART_MAX), 0);
        send_item(make_item(OP_ADD, PART_MIN, PART_MIN, PART_MIN, PART_MIN), 0);
        send_item(make_item(OP_ADD, PART_MAX, PART_MIN, 0, 0), 0);
        send_item(make_item(OP_ADD, 1, -1, -1, 1), 0);
        send_item(make_item(OP_SUB, PART_MIN, PART_MAX, PART_MAX, PART_MIN), 0);
        send_item(make_item(OP_SUB, PART_MAX, PART_MIN, PART_MAX, PART_MIN), 0);
        send_item(make_item(OP_SUB, 0, 0, PART_MIN, PART_MIN), 0);
    endtask

    task automatic test_multiply_cases();
        send_item(make_item(OP_MUL, PART_MIN, PART_MIN, PART_MIN, PART_MIN), 0);
        send_item(make_item(OP_MUL, PART_MAX, PART_MAX, PART_MAX, -PART_MAX), 0);
        send_item(make_item(OP_MUL, 256, 0, -1234, 5678), 0);
        send_item(make_item(OP_MUL, -1, 0, 1, 0), 0);     // floors to -1
        send_item(make_item(OP_MUL, 384, 128, -256, 512), 0);
        send_item(make_item(OP_MUL, 0, 0, PART_MIN, PART_MAX), 0);
    endtask

    task automatic test_divide_cases();
        send_item(make_item(OP_DIV, PART_MAX, PART_MIN, 0, 0), 0);   // zero divisor
        send_item(make_item(OP_DIV, 0, 0, 0, 0), 0);
        send_item(make_item(OP_DIV, PART_MAX, PART_MAX, 1, 0), 0);   // saturates
        send_item(make_item(OP_DIV, 256, 256, 256, 256), 0);
        send_item(make_item(OP_DIV, -1, 0, 3, 0), 0);                // truncates toward zero
        send_item(make_item(OP_DIV, PART_MIN, PART_MIN, PART_MIN, PART_MIN), 0);
        send_item(make_item(OP_DIV, 100, -200, PART_MAX, PART_MIN), 0);
        send_item(make_item(OP_DIV, PART_MIN, PART_MAX, 0, -1), 0);
    endtask

    // Mix of extremes, small and medium magnitudes, and full-range values.
    function automatic longint random_part();
        case ($urandom_range(9))
            0:       return PART_MAX;
            1:       return PART_MIN;
            2:       return 0;
            3, 4:    return longint'($urandom_range(2048)) - 1024;
            5, 6:    return longint'($urandom_range(16384)) - 8192;
            default: return longint'(int'($urandom));
        endcase
    endfunction

    task automatic test_random_traffic(input int count, input int idle_pct);
        t_operands item;
        repeat (count) begin
            item = make_item(2'($urandom_range(3)), random_part(), random_part(),
                             random_part(), random_part());
            if (item.opcode == OP_DIV && $urandom_range(15) == 0) begin
                item.b_re = '0;
                item.b_im = '0;
            end
            send_item(item, idle_pct);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_add_sub_extremes();
        test_multiply_cases();
        test_divide_cases();
        test_random_traffic(300, 0);
        test_random_traffic(300, 66);
        test_random_traffic(300, 6);

        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (C_LATENCY + 4) @(posedge i_clk);

        $display("Covered %0d items (%0d results) over all four opcodes,", item_count,
                 result_count);
        $display("with saturation, zero divisors and sender idle rates of 0, 66 and 6 percent.");
        if (error_count == 0) begin
            $display("complex_arithmetic_unit_test: clean");
        end else begin
            $display("complex_arithmetic_unit_test: errors");
        end
        $finish;
    end

endmodule
